// File: design/tbf_pkg.sv
// Package for the tabulated bond force block: payload types, commands, state codes.
// Used by tbf_divider and tabulated_bond_force; no dependencies.
package tbf_pkg;

  localparam int MAX_BONDS_DEF = 256;
  localparam int MAX_BINS_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_LENGTH = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         bond_index;
    logic [9:0]         bin_index;
    logic signed [31:0] potential_value;
    logic signed [31:0] derivative_value;
    logic [10:0]        table_length;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } in_req_t;

  typedef struct packed {
    logic               in_range;
    logic signed [31:0] energy_term;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [39:0] energy_total;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_BIN,
    ST_LOOKUP,
    ST_READ,
    ST_FORCE_MUL,
    ST_FORCE_DIV,
    ST_OUT
  } state_t;

  // Start, busy and done status for the shared divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: design/tbf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module tbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/tbf_divider.sv
// Bit-serial restoring divider: unsigned 64 by 34 bits, one quotient bit per cycle.
// Depends on tbf_pkg for the control struct.
module tbf_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [33:0]         divisor,
  output logic [63:0]         quotient,
  output tbf_pkg::div_ctl_t   status
);

  logic [63:0] quo_r, quo_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [33:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] shifted;
  logic [35:0] diff;

  // Shift one dividend bit into the remainder and try a subtract
  always_comb begin
    shifted  = {rem_r[33:0], quo_r[63]};
    diff     = {1'b0, shifted} - {2'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[35]) begin
        rem_nxt = diff[34:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient      = quo_r;
  assign status.start  = start;
  assign status.busy   = busy_r;
  assign status.done   = done_r;

endmodule

// File: design/tabulated_bond_force.sv
// Tabulated bond force: per-bond energy/derivative tables, Q16.16 distance and force.
// Load and length requests are written on acceptance; a finish result is valid the next
// cycle. An evaluation runs the squares, the square root, the bin division and the lookup,
// then per axis a product and a force division; an out-of-range bin or a zero r skips the
// force steps. One request at a time; a pending result stalls input. Reset clears lengths
// and the energy total, sets bin_width to 65536.
module tabulated_bond_force #(
  parameter int MAX_BONDS = tbf_pkg::MAX_BONDS_DEF,
  parameter int MAX_BINS  = tbf_pkg::MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tbf_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tbf_pkg::out_req_t  out_data,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata
);

  localparam int BOND_W = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int ADDR_W = BOND_W + BIN_W;
  localparam int LEN_W  = $clog2(MAX_BINS + 1);
  localparam int DEPTH  = MAX_BONDS * MAX_BINS;
  localparam logic [39:0] E_MAX = {1'b0, {39{1'b1}}};
  localparam logic [39:0] E_MIN = {1'b1, 39'd0};

  tbf_pkg::state_t state_r, state_nxt;
  tbf_pkg::in_req_t req_r;
  logic [30:0] bw_r;
  logic [39:0] acc_r;
  logic [MAX_BONDS-1:0] len_vld_r;

  logic [32:0] d_r [3];
  logic [32:0] m_r;         // magnitude being squared
  logic [65:0] mc_r;        // multiplicand shifted left
  logic [65:0] sq_r;        // sum of squares
  logic [1:0]  axis_r;
  logic [5:0]  step_r;
  logic [33:0] root_r;
  logic [35:0] rem_r;
  logic [65:0] sqv_r;
  logic        bond_ok_r, in_rng_r;
  logic [63:0] bin_r;
  logic signed [31:0] pot_r, der_r;
  logic [63:0] prod_r;
  logic [31:0] dm_r;
  logic [32:0] mul_r;
  logic [31:0] f_r [3];
  logic        div_go_r, div_go_nxt;
  logic        div_phase_r;  // 0 bin division, 1 force division
  logic        out_valid_r;
  tbf_pkg::out_req_t out_r;

  logic accept;
  logic [ADDR_W-1:0] ram_addr;
  logic ram_we;
  logic [31:0] pot_rd, der_rd;
  logic [63:0] div_q;
  tbf_pkg::div_ctl_t div_st;
  logic [63:0] div_dend;
  logic [33:0] div_dsor;
  logic len_we;
  logic [BOND_W-1:0] len_addr;
  logic [LEN_W-1:0] len_rd;

  assign in_stall = (state_r != tbf_pkg::ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Table memories
  assign ram_we = accept && (in_data.cmd == tbf_pkg::CMD_LOAD)
                  && ({24'd0, in_data.bond_index} < 32'(MAX_BONDS))
                  && ({22'd0, in_data.bin_index} < 32'(MAX_BINS));
  always_comb begin
    if (state_r == tbf_pkg::ST_LOOKUP) begin
      ram_addr = {req_r.bond_index[BOND_W-1:0], bin_r[BIN_W-1:0]};
    end else begin
      ram_addr = {in_data.bond_index[BOND_W-1:0], in_data.bin_index[BIN_W-1:0]};
    end
  end

  tbf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pot (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(in_data.potential_value), .rdata(pot_rd)
  );
  tbf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_der (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(in_data.derivative_value), .rdata(der_rd)
  );

  // Per-bond table lengths: written on a length request, read for the held request
  assign len_we = accept && (in_data.cmd == tbf_pkg::CMD_LENGTH)
                  && ({24'd0, in_data.bond_index} < 32'(MAX_BONDS));
  assign len_addr = (state_r == tbf_pkg::ST_IDLE) ? in_data.bond_index[BOND_W-1:0]
                                                  : req_r.bond_index[BOND_W-1:0];
  tbf_ram #(.WIDTH(LEN_W), .DEPTH(MAX_BONDS)) u_len (
    .clk(clk), .we(len_we), .addr(len_addr),
    .wdata(LEN_W'(len_sat)), .rdata(len_rd)
  );

  // Shared divider: bin = r / bw, force = |d|*|der| / r
  assign div_dend = div_phase_r ? prod_r : {30'd0, root_r};
  assign div_dsor = div_phase_r ? root_r :
                    ((bw_r == 31'd0) ? 34'd1 : {3'd0, bw_r});
  tbf_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .dividend(div_dend), .divisor(div_dsor),
    .quotient(div_q), .status(div_st)
  );

  // Start the divider after the last root bit and after the last product digit
  assign div_go_nxt = ((state_r == tbf_pkg::ST_SQRT) && (step_r == 6'd0))
                      || ((state_r == tbf_pkg::ST_FORCE_MUL) && (step_r == 6'd16));

  // Square-root trial subtraction for one result bit
  logic [35:0] sr_rem;
  logic [35:0] sr_trial;
  logic [6:0]  sr_sh;
  logic [67:0] sqv_ext;
  always_comb begin
    sr_sh    = 7'(step_r) << 1;
    sqv_ext  = {2'b00, sqv_r};
    sr_rem   = {rem_r[33:0], sqv_ext[sr_sh + 7'd1], sqv_ext[sr_sh]};
    sr_trial = {root_r, 2'b01};
  end

  // Saturated force component from quotient and sign
  function automatic logic [31:0] sat_force(input logic [63:0] q, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
    end else begin
      res = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return res;
  endfunction

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbf_pkg::ST_IDLE: begin
        if (accept && (in_data.cmd == tbf_pkg::CMD_EVAL)) begin
          state_nxt = tbf_pkg::ST_SQUARE;
        end
      end
      tbf_pkg::ST_SQUARE: begin
        if (step_r == 6'd16 && axis_r == 2'd2) begin
          state_nxt = tbf_pkg::ST_SQRT;
        end
      end
      tbf_pkg::ST_SQRT: begin
        if (step_r == 6'd0) begin
          state_nxt = tbf_pkg::ST_BIN;
        end
      end
      tbf_pkg::ST_BIN: begin
        if (div_st.done) begin
          state_nxt = tbf_pkg::ST_LOOKUP;
        end
      end
      tbf_pkg::ST_LOOKUP: state_nxt = tbf_pkg::ST_READ;
      tbf_pkg::ST_READ: begin
        if (!in_rng_r || root_r == 34'd0) begin
          state_nxt = tbf_pkg::ST_OUT;
        end else begin
          state_nxt = tbf_pkg::ST_FORCE_MUL;
        end
      end
      tbf_pkg::ST_FORCE_MUL: begin
        if (step_r == 6'd16) begin
          state_nxt = tbf_pkg::ST_FORCE_DIV;
        end
      end
      tbf_pkg::ST_FORCE_DIV: begin
        if (div_st.done) begin
          state_nxt = (axis_r == 2'd2) ? tbf_pkg::ST_OUT : tbf_pkg::ST_FORCE_MUL;
        end
      end
      tbf_pkg::ST_OUT: state_nxt = tbf_pkg::ST_IDLE;
      default: state_nxt = tbf_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers
  logic [39:0] acc_sum;
  logic [40:0] acc_wide;
  logic [LEN_W-1:0] len_sel;
  logic [10:0] len_sat;
  always_comb begin
    acc_wide = {acc_r[39], acc_r} + {{9{pot_rd[31]}}, pot_rd};
    if (acc_wide[40] != acc_wide[39]) begin
      acc_sum = acc_wide[40] ? E_MIN : E_MAX;
    end else begin
      acc_sum = acc_wide[39:0];
    end
    len_sel = len_vld_r[req_r.bond_index[BOND_W-1:0]] ? len_rd : '0;
    len_sat = (in_data.table_length > 11'(MAX_BINS)) ? 11'(MAX_BINS)
              : in_data.table_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbf_pkg::ST_IDLE;
      bw_r        <= 31'd65536;
      acc_r       <= '0;
      len_vld_r   <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= div_go_nxt;
      if (cfg_we) begin
        bw_r <= cfg_wdata;
      end
      // Drop the result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        req_r <= in_data;
        case (in_data.cmd)
          tbf_pkg::CMD_LENGTH: begin
            if ({24'd0, in_data.bond_index} < 32'(MAX_BONDS)) begin
              len_vld_r[in_data.bond_index[BOND_W-1:0]] <= 1'b1;
            end
          end
          tbf_pkg::CMD_FINISH: begin
            out_r <= '{in_range: 1'b0, energy_term: 32'sd0, force_x: 32'sd0,
                       force_y: 32'sd0, force_z: 32'sd0, energy_total: acc_r};
            acc_r       <= '0;
            out_valid_r <= 1'b1;
          end
          tbf_pkg::CMD_EVAL: begin
            d_r[0] <= {in_data.first_x[31], in_data.first_x}
                      - {in_data.second_x[31], in_data.second_x};
            d_r[1] <= {in_data.first_y[31], in_data.first_y}
                      - {in_data.second_y[31], in_data.second_y};
            d_r[2] <= {in_data.first_z[31], in_data.first_z}
                      - {in_data.second_z[31], in_data.second_z};
            sq_r   <= '0;
            axis_r <= 2'd0;
            step_r <= 6'd0;
          end
          default: ;
        endcase
      end
      case (state_r)
        // Squares: 2 multiplier bits a cycle, step 0 loads the operand
        tbf_pkg::ST_SQUARE: begin
          if (step_r == 6'd0) begin
            m_r  <= d_r[axis_r][32] ? 33'd0 - d_r[axis_r] : d_r[axis_r];
            mc_r <= {33'd0, (d_r[axis_r][32] ? 33'd0 - d_r[axis_r] : d_r[axis_r])};
            step_r <= 6'd1;
          end else begin
            sq_r <= sq_r + (m_r[0] ? mc_r : 66'd0) + (m_r[1] ? {mc_r[64:0], 1'b0} : 66'd0);
            m_r  <= m_r >> 2;
            mc_r <= mc_r << 2;
            // Magnitudes fit 32 bits, so 16 digits finish the last axis
            if (step_r == 6'd16 && axis_r == 2'd2) begin
              sqv_r  <= sq_r + (m_r[0] ? mc_r : 66'd0)
                        + (m_r[1] ? {mc_r[64:0], 1'b0} : 66'd0);
              rem_r  <= '0;
              root_r <= '0;
              step_r <= 6'd33;
            end else if (step_r == 6'd17) begin
              axis_r <= axis_r + 2'd1;
              step_r <= 6'd0;
            end else begin
              step_r <= step_r + 6'd1;
            end
          end
        end
        // Square root: one result bit a cycle
        tbf_pkg::ST_SQRT: begin
          if (sr_rem >= sr_trial) begin
            rem_r  <= sr_rem - sr_trial;
            root_r <= {root_r[32:0], 1'b1};
          end else begin
            rem_r  <= sr_rem;
            root_r <= {root_r[32:0], 1'b0};
          end
          step_r <= step_r - 6'd1;
          if (step_r == 6'd0) begin
            div_phase_r <= 1'b0;
          end
        end
        tbf_pkg::ST_BIN: begin
          if (div_st.done) begin
            bin_r     <= div_q;
            bond_ok_r <= {24'd0, req_r.bond_index} < 32'(MAX_BONDS);
          end
        end
        tbf_pkg::ST_LOOKUP: begin
          in_rng_r <= bond_ok_r && (bin_r < 64'(len_sel));
        end
        // Table data arrives; add energy when in range
        tbf_pkg::ST_READ: begin
          pot_r  <= pot_rd;
          der_r  <= der_rd;
          f_r[0] <= '0;
          f_r[1] <= '0;
          f_r[2] <= '0;
          axis_r <= 2'd0;
          step_r <= 6'd0;
          if (in_rng_r) begin
            acc_r <= acc_sum;
          end
        end
        // |d| * |der|: two bits of |d| a cycle, step 0 loads
        tbf_pkg::ST_FORCE_MUL: begin
          if (step_r == 6'd0) begin
            mul_r  <= d_r[axis_r][32] ? 33'd0 - d_r[axis_r] : d_r[axis_r];
            dm_r   <= der_r[31] ? 32'd0 - der_r : der_r;
            prod_r <= '0;
            step_r <= 6'd1;
          end else begin
            prod_r <= prod_r
                      + (mul_r[0] ? {32'd0, dm_r} << (7'(step_r - 6'd1) << 1) : 64'd0)
                      + (mul_r[1] ? {32'd0, dm_r} << ((7'(step_r - 6'd1) << 1) + 7'd1)
                                  : 64'd0);
            mul_r  <= mul_r >> 2;
            step_r <= step_r + 6'd1;
            if (step_r == 6'd16) begin
              div_phase_r <= 1'b1;
            end
          end
        end
        tbf_pkg::ST_FORCE_DIV: begin
          if (div_st.done) begin
            f_r[axis_r] <= sat_force(div_q, d_r[axis_r][32] ^ der_r[31]);
            axis_r <= axis_r + 2'd1;
            step_r <= 6'd0;
          end
        end
        tbf_pkg::ST_OUT: begin
          out_r <= '{in_range: in_rng_r, energy_term: (in_rng_r ? pot_r : 32'sd0),
                     force_x: f_r[0], force_y: f_r[1], force_z: f_r[2],
                     energy_total: 40'sd0};
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
